@@ src/kcde_pkg.sv @@
// Package for the k-core and degeneracy engine.
// Holds the request and response word types, status codes and sequencer states.
package kcde_pkg;

  localparam int FieldW = 10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_DONE = 2'd1,
    ST_RANGE    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              req_type;
    logic [FieldW-1:0] neighbor;
    logic              vertex_end;
    logic              empty_vertex;
    logic              graph_end;
    logic [FieldW-1:0] query_index;
  } req_t;

  typedef struct packed {
    logic [FieldW-1:0] core_number;
    logic [FieldW-1:0] order_vertex;
    logic [1:0]        status;
  } rsp_t;

  typedef enum logic [4:0] {
    S_LOAD, S_QRY, S_CLR,
    S_DEG_RS, S_DEG_RE, S_DEG_E2, S_DEG_RD, S_DEG_CHK, S_DEG_BW,
    S_PRE_RD, S_PRE_WR,
    S_PL_RC, S_PL_RB, S_PL_WR,
    S_SH_RD, S_SH_WR,
    S_PE_RO, S_PE_RC, S_PE_RS, S_PE_RE, S_PE_RA, S_PE_CU, S_PE_CD,
    S_PE_RB, S_PE_RW, S_PE_W2
  } state_e;

endpackage

@@ src/kcde_req_if.sv @@
// Request channel of the k-core engine: valid, ready and one request word.
// Depends on kcde_pkg.
interface kcde_req_if import kcde_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/kcde_rsp_if.sv @@
// Response channel of the k-core engine: valid, ready and one response word.
// Depends on kcde_pkg.
interface kcde_rsp_if import kcde_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/kcde_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kcde_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ src/kcore_and_degeneracy_engine.sv @@
// Top level of the k-core decomposition and degeneracy order engine.
// Depends on kcde_pkg, kcde_req_if, kcde_rsp_if and kcde_ram.
//
// The load word flagged graph_end starts the peeling, during which no word is
// accepted. The peeling runs in these passes:
//   - a clearing pass over the bin table;
//   - the degrees, counted per vertex over its entries;
//   - the bin prefix;
//   - the placement, then the bin shift;
//   - the peel.
// The single read port and the registered read of each graph memory turn the bin
// count updates and the core decrements into read-modify-write sequences. A
// query word addresses the core and order memories directly, and its result
// sits in an output register until it is taken.
module kcore_and_degeneracy_engine import kcde_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_ENTRIES  = 8192
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  kcde_req_if.sink   req_i,
  kcde_rsp_if.source rsp_o
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = $clog2(MAX_ENTRIES + 1);

  state_e state_q, state_d;

  logic [NW-1:0] vt_q, v_q, d_q, start_q, b_q;
  logic [EW-1:0] et_q, ostart_q, k_q, kend_q;
  logic [VW-1:0] oc_q, deg_q, cv_q, vv_q, cvv_q, u_q, du_q, pu_q, w_q;
  logic          done_q, ovf_q;
  logic [1:0]    qstat_q;
  logic          rsp_valid_q;
  rsp_t          rsp_q;

  // Memory ports.
  logic          adj_we;
  logic [AW-1:0] adj_wa, adj_ra;
  logic [VW-1:0] adj_wd, adj_rd;
  logic          ls_we;
  logic [VW-1:0] ls_wa, ls_ra;
  logic [EW-1:0] ls_wd, ls_rd;
  logic          core_we;
  logic [VW-1:0] core_wa, core_ra, core_wd, core_rd;
  logic          ord_we;
  logic [VW-1:0] ord_wa, ord_ra, ord_wd, ord_rd;
  logic          pos_we;
  logic [VW-1:0] pos_wa, pos_ra, pos_wd, pos_rd;
  logic          bin_we;
  logic [VW-1:0] bin_wa, bin_ra;
  logic [NW-1:0] bin_wd, bin_rd;

  kcde_ram #(.Width(VW), .Depth(MAX_ENTRIES)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd),
    .raddr_i(adj_ra), .rdata_o(adj_rd));
  kcde_ram #(.Width(EW), .Depth(MAX_VERTICES)) u_ls (
    .clk_i, .we_i(ls_we), .waddr_i(ls_wa), .wdata_i(ls_wd),
    .raddr_i(ls_ra), .rdata_o(ls_rd));
  kcde_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_core (
    .clk_i, .we_i(core_we), .waddr_i(core_wa), .wdata_i(core_wd),
    .raddr_i(core_ra), .rdata_o(core_rd));
  kcde_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_ord (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd),
    .raddr_i(ord_ra), .rdata_o(ord_rd));
  kcde_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_wa), .wdata_i(pos_wd),
    .raddr_i(pos_ra), .rdata_o(pos_rd));
  kcde_ram #(.Width(NW), .Depth(MAX_VERTICES)) u_bin (
    .clk_i, .we_i(bin_we), .waddr_i(bin_wa), .wdata_i(bin_wd),
    .raddr_i(bin_ra), .rdata_o(bin_rd));

  logic req_acc, is_load, add_ok, do_close, vt_room;
  logic [NW-1:0] v_next, vv_next;

  assign req_acc  = req_i.valid && req_i.ready;
  assign is_load  = req_acc && (req_i.data.req_type == REQ_LOAD) && !done_q;
  assign vt_room  = 32'(vt_q) < MAX_VERTICES;
  assign add_ok   = vt_room && !req_i.data.empty_vertex
                 && (32'(req_i.data.neighbor) < MAX_VERTICES)
                 && (32'(et_q) < MAX_ENTRIES)
                 && (32'(oc_q) < MAX_VERTICES - 1);
  assign do_close = req_i.data.empty_vertex || req_i.data.vertex_end
                 || req_i.data.graph_end;
  assign v_next   = v_q + NW'(1);
  assign vv_next  = NW'(vv_q) + NW'(1);

  assign req_i.ready = (state_q == S_LOAD) && !rsp_valid_q;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (req_acc && req_i.data.req_type == REQ_QUERY) state_d = S_QRY;
        else if (is_load && req_i.data.graph_end) state_d = S_CLR;
      end
      S_QRY:     state_d = S_LOAD;
      S_CLR:     if (32'(d_q) == MAX_VERTICES - 1) state_d = S_DEG_RS;
      S_DEG_RS:  state_d = (v_q == vt_q) ? S_PRE_RD : S_DEG_RE;
      S_DEG_RE:  state_d = S_DEG_E2;
      S_DEG_E2:  state_d = S_DEG_RD;
      S_DEG_RD:  state_d = (k_q == kend_q) ? S_DEG_BW : S_DEG_CHK;
      S_DEG_CHK: state_d = S_DEG_RD;
      S_DEG_BW:  state_d = S_DEG_RS;
      S_PRE_RD:  state_d = (32'(d_q) == MAX_VERTICES) ? S_PL_RC : S_PRE_WR;
      S_PRE_WR:  state_d = S_PRE_RD;
      S_PL_RC:   state_d = (v_q == vt_q) ? S_SH_RD : S_PL_RB;
      S_PL_RB:   state_d = S_PL_WR;
      S_PL_WR:   state_d = S_PL_RC;
      S_SH_RD:   state_d = (d_q == '0) ? S_PE_RO : S_SH_WR;
      S_SH_WR:   state_d = S_SH_RD;
      S_PE_RO:   state_d = (v_q == vt_q) ? S_LOAD : S_PE_RC;
      S_PE_RC:   state_d = S_PE_RS;
      S_PE_RS:   state_d = S_PE_RE;
      S_PE_RE:   state_d = S_PE_RA;
      S_PE_RA:   state_d = (k_q == kend_q) ? S_PE_RO : S_PE_CU;
      S_PE_CU:   state_d = (NW'(adj_rd) < vt_q) ? S_PE_CD : S_PE_RA;
      S_PE_CD:   state_d = (core_rd > cvv_q) ? S_PE_RB : S_PE_RA;
      S_PE_RB:   state_d = S_PE_RW;
      S_PE_RW:   state_d = (u_q != ord_rd) ? S_PE_W2 : S_PE_RA;
      S_PE_W2:   state_d = S_PE_RA;
      default:   state_d = S_LOAD;
    endcase
  end

  // Memory control.
  always_comb begin
    adj_we = 1'b0; adj_wa = AW'(et_q); adj_wd = VW'(req_i.data.neighbor);
    adj_ra = AW'(k_q);
    ls_we = 1'b0; ls_wa = VW'(vt_q); ls_wd = ostart_q; ls_ra = VW'(v_q);
    core_we = 1'b0; core_wa = VW'(v_q); core_wd = deg_q;
    core_ra = VW'(req_i.data.query_index);
    ord_we = 1'b0; ord_wa = VW'(bin_rd); ord_wd = VW'(v_q);
    ord_ra = VW'(req_i.data.query_index);
    pos_we = 1'b0; pos_wa = VW'(v_q); pos_wd = VW'(bin_rd); pos_ra = u_q;
    bin_we = 1'b0; bin_wa = VW'(d_q); bin_wd = '0; bin_ra = VW'(d_q);
    unique case (state_q)
      S_LOAD: begin
        adj_we = is_load && add_ok;
        ls_we  = is_load && do_close && vt_room;
      end
      S_CLR: bin_we = 1'b1;
      S_DEG_RE: ls_ra = VW'(v_next);
      S_DEG_RD: begin
        bin_ra = deg_q;
        core_we = (k_q == kend_q);
      end
      S_DEG_BW: begin
        bin_we = 1'b1; bin_wa = deg_q; bin_wd = bin_rd + NW'(1);
      end
      S_PRE_WR: begin
        bin_we = 1'b1; bin_wd = start_q;
      end
      S_PL_RC: core_ra = VW'(v_q);
      S_PL_RB: bin_ra = core_rd;
      S_PL_WR: begin
        pos_we = 1'b1; ord_we = 1'b1;
        bin_we = 1'b1; bin_wa = cv_q; bin_wd = bin_rd + NW'(1);
      end
      S_SH_RD: begin
        bin_ra = VW'(d_q - NW'(1));
        bin_we = (d_q == '0);
      end
      S_SH_WR: begin
        bin_we = 1'b1; bin_wd = bin_rd;
      end
      S_PE_RO: ord_ra = VW'(v_q);
      S_PE_RC: begin
        core_ra = ord_rd; ls_ra = ord_rd;
      end
      S_PE_RS: ls_ra = VW'(vv_next);
      S_PE_CU: core_ra = adj_rd;
      S_PE_CD: bin_ra = core_rd;
      S_PE_RB: ord_ra = VW'(bin_rd);
      S_PE_RW: begin
        bin_we = 1'b1; bin_wa = du_q; bin_wd = b_q + NW'(1);
        core_we = 1'b1; core_wa = u_q; core_wd = du_q - VW'(1);
        pos_we = (u_q != ord_rd); pos_wa = u_q; pos_wd = VW'(b_q);
        ord_we = (u_q != ord_rd); ord_wa = pu_q; ord_wd = ord_rd;
      end
      S_PE_W2: begin
        pos_we = 1'b1; pos_wa = w_q; pos_wd = pu_q;
        ord_we = 1'b1; ord_wa = VW'(b_q); ord_wd = u_q;
      end
      default: ;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      vt_q <= '0; et_q <= '0; ostart_q <= '0; oc_q <= '0;
      done_q <= 1'b0; ovf_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      v_q <= '0; d_q <= '0; k_q <= '0; kend_q <= '0;
      qstat_q <= ST_OK;
    end else begin
      state_q <= state_d;
      if (rsp_valid_q && rsp_o.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (req_acc && req_i.data.req_type == REQ_QUERY) begin
            if (!done_q) qstat_q <= ST_NOT_DONE;
            else if (32'(req_i.data.query_index) >= 32'(vt_q)) qstat_q <= ST_RANGE;
            else qstat_q <= ovf_q ? ST_OVERFLOW : ST_OK;
          end
          if (is_load) begin
            if ((!req_i.data.empty_vertex && !add_ok) || (do_close && !vt_room)) begin
              ovf_q <= 1'b1;
            end
            if (add_ok) et_q <= et_q + EW'(1);
            if (do_close) begin
              if (vt_room) vt_q <= vt_q + NW'(1);
              ostart_q <= et_q + EW'(add_ok);
              oc_q <= '0;
            end else if (add_ok) begin
              oc_q <= oc_q + VW'(1);
            end
            d_q <= '0;
          end
        end
        S_QRY: begin
          rsp_valid_q <= 1'b1;
          rsp_q.status <= qstat_q;
          if (qstat_q == ST_OK || qstat_q == ST_OVERFLOW) begin
            rsp_q.core_number  <= FieldW'(core_rd);
            rsp_q.order_vertex <= FieldW'(ord_rd);
          end else begin
            rsp_q.core_number  <= '0;
            rsp_q.order_vertex <= '0;
          end
        end
        S_CLR: begin
          d_q <= d_q + NW'(1);
          v_q <= '0;
        end
        S_DEG_RS: begin
          d_q <= '0;
          start_q <= '0;
        end
        S_DEG_RE: k_q <= ls_rd;
        S_DEG_E2: begin
          kend_q <= (v_next < vt_q) ? ls_rd : et_q;
          deg_q <= '0;
        end
        S_DEG_RD: if (k_q != kend_q) k_q <= k_q + EW'(1);
        S_DEG_CHK: if (NW'(adj_rd) < vt_q) deg_q <= deg_q + VW'(1);
        S_DEG_BW: v_q <= v_next;
        S_PRE_RD: v_q <= '0;
        S_PRE_WR: begin
          start_q <= start_q + bin_rd;
          d_q <= d_q + NW'(1);
        end
        S_PL_RC: d_q <= NW'(MAX_VERTICES - 1);
        S_PL_RB: cv_q <= core_rd;
        S_PL_WR: v_q <= v_next;
        S_SH_RD: v_q <= '0;
        S_SH_WR: d_q <= d_q - NW'(1);
        S_PE_RO: if (v_q == vt_q) done_q <= 1'b1;
        S_PE_RC: vv_q <= ord_rd;
        S_PE_RS: begin
          cvv_q <= core_rd;
          k_q <= ls_rd;
        end
        S_PE_RE: kend_q <= (vv_next < vt_q) ? ls_rd : et_q;
        S_PE_RA: begin
          if (k_q == kend_q) v_q <= v_next;
          else k_q <= k_q + EW'(1);
        end
        S_PE_CU: u_q <= adj_rd;
        S_PE_CD: du_q <= core_rd;
        S_PE_RB: begin
          pu_q <= pos_rd;
          b_q <= bin_rd;
        end
        S_PE_RW: w_q <= ord_rd;
        default: ;
      endcase
    end
  end

  // The request port is open only while the sequencer waits for words.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (state_q == S_LOAD))
    else $error("request ready outside the load state");

  a_vt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(vt_q) <= MAX_VERTICES)
    else $error("vertex total beyond capacity");

  a_query_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.data.req_type == REQ_QUERY) |=> (state_q == S_QRY))
    else $error("query word not followed by the read cycle");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == S_QRY))
    else $error("response raised outside a query");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(done_q) |-> done_q)
    else $error("done flag dropped");
endmodule
